>>> sv/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// shared constants, codes, types and the block-index function of the
// allocation-table entry cache
// ----------------------------------------------------------------------------
package fcd_pkg;

	localparam int ENTRIES    = 4096;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int MAX_BLOCKS = 64;
	localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int DATA_W     = 32;
	localparam int OP_W       = 3;
	localparam int ST_W       = 3;
	localparam int BSL_W      = 4;
	localparam int ADDR_W     = 4;

	// special entry values: top 28 bits all ones
	localparam logic [DATA_W-1:0] SPECIAL_MASK = 32'hFFFF_FFF0;
	// entries are four bytes
	localparam int ENTRY_BYTES_LOG2 = 2;
	localparam logic [BSL_W-1:0] MIN_BSL = 4'd8;

	// operations
	localparam logic [OP_W-1:0] OP_GET   = 3'd0;
	localparam logic [OP_W-1:0] OP_SET   = 3'd1;
	localparam logic [OP_W-1:0] OP_FILL  = 3'd2;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd3;
	localparam logic [OP_W-1:0] OP_MARK  = 3'd4;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd5;
	localparam logic [OP_W-1:0] OP_INVAL = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
	localparam logic [ST_W-1:0] STAT_RANGE     = 3'd1;
	localparam logic [ST_W-1:0] STAT_ILLEGAL   = 3'd2;
	localparam logic [ST_W-1:0] STAT_NOT_LOAD  = 3'd3;
	localparam logic [ST_W-1:0] STAT_NOTHING   = 3'd4;

	// register indexes
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_BLOCK_LOG2  = 2'd1;
	localparam logic [1:0] REG_FIRST_BLOCK = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0]  entry_count;
		logic [BSL_W-1:0]  block_size_log2;
		logic [DATA_W-1:0] first_table_block;
	} cfg_t;

	typedef struct packed {
		logic             mark;
		logic [BLK_W-1:0] blk;
		logic             clear_all;
		logic             take;
		logic             set_any;
		logic             clr_any;
	} dm_cmd_t;

	typedef struct packed {
		logic             nonempty;
		logic             any_dirty;
		logic [BLK_W-1:0] low_blk;
		logic             rest_empty;
	} dm_stat_t;

	// disk block of an entry, saturated at the last block
	function automatic logic [BLK_W-1:0] block_of(input logic [IDX_W-1:0] idx,
		input logic [BSL_W-1:0] bsl);
		logic [BSL_W-1:0]                  lg;
		logic [IDX_W+ENTRY_BYTES_LOG2-1:0] b;
		lg = (bsl < MIN_BSL) ? MIN_BSL : bsl;
		b  = {idx, {ENTRY_BYTES_LOG2{1'b0}}} >> lg;
		if (b >= (IDX_W+ENTRY_BYTES_LOG2)'(MAX_BLOCKS - 1)) begin
			return BLK_W'(MAX_BLOCKS - 1);
		end
		return b[BLK_W-1:0];
	endfunction

endpackage

>>> sv/fat_entry_cache_dirty_map_top.sv
// ----------------------------------------------------------------------------
// fat_entry_cache_dirty_map_top
// allocation-table entry cache with per-block dirty map and flush sequencer
// ----------------------------------------------------------------------------
// set, load entry, mark loaded, errors: result the cycle after the transfer,
//   next command the cycle after; get: registered ram read, read state, then result
// fill: one entry written per cycle, result after the last write
// flush: one dirty block per cycle, one result per block
// invalidate and reset: clearing pass over all 4096 ram entries (busy high);
//   after reset no result is produced; results cannot be stalled
module fat_entry_cache_dirty_map_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [fcd_pkg::OP_W-1:0]      operation,
	input  logic [fcd_pkg::IDX_W-1:0]     index,
	input  logic [fcd_pkg::CNT_W-1:0]     index_end,
	input  logic [fcd_pkg::DATA_W-1:0]    value,
	// result channel
	output logic                          done,
	output logic [fcd_pkg::DATA_W-1:0]    entry_value,
	output logic [fcd_pkg::DATA_W-1:0]    block_number,
	output logic [fcd_pkg::ST_W-1:0]      status,
	output logic                          last,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcd_pkg::ADDR_W-1:0]    paddr,
	input  logic [fcd_pkg::DATA_W-1:0]    pwdata,
	output logic [fcd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_GET   = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;

	fcd_pkg::cfg_t     cfg;
	fcd_pkg::dm_cmd_t  dm_cmd;
	fcd_pkg::dm_stat_t dm_stat;

	logic [2:0]                   state_q;
	logic [2:0]                   state_nxt;
	logic [fcd_pkg::IDX_W-1:0]    x_q;       // fill / clear walk pointer
	logic [fcd_pkg::CNT_W-1:0]    end_q;     // exclusive fill end
	logic [fcd_pkg::DATA_W-1:0]   fill_val_q;
	logic                         loaded_q;
	logic                         report_q;  // clearing pass owes a result

	logic                         accept;
	logic [fcd_pkg::CNT_W-1:0]    usable;
	logic                         idx_oor;
	logic                         val_ok;
	logic                         set_ok;
	logic                         fill_go;
	logic                         flush_go;
	logic                         fill_final;
	logic                         clear_final;

	logic                         mem_we;
	logic [fcd_pkg::IDX_W-1:0]    mem_waddr;
	logic [fcd_pkg::DATA_W-1:0]   mem_wdata;
	logic [fcd_pkg::DATA_W-1:0]   mem_rdata;

	// result about to be registered
	logic                         emit;
	logic [fcd_pkg::ST_W-1:0]     emit_status;
	logic                         emit_last;
	logic [fcd_pkg::DATA_W-1:0]   emit_ev;
	logic [fcd_pkg::DATA_W-1:0]   emit_bn;

	logic                         done_q;
	logic [fcd_pkg::ST_W-1:0]     status_q;
	logic                         last_q;
	logic [fcd_pkg::DATA_W-1:0]   ev_q;
	logic [fcd_pkg::DATA_W-1:0]   bn_q;

	fcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fcd_table u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (index),
		.rdata (mem_rdata)
	);

	fcd_dirty_map u_dirty (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dm_cmd),
		.stat   (dm_stat)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	// usable entry count: lesser of the register and the table depth
	assign usable = (cfg.entry_count > fcd_pkg::CNT_W'(fcd_pkg::ENTRIES)) ?
		fcd_pkg::CNT_W'(fcd_pkg::ENTRIES) : cfg.entry_count;
	assign idx_oor = ({1'b0, index} >= usable);
	// ordinary values must stay below the entry count, special ones pass
	assign val_ok  = ((value & fcd_pkg::SPECIAL_MASK) == fcd_pkg::SPECIAL_MASK) ||
		(value < fcd_pkg::DATA_W'(cfg.entry_count));
	assign set_ok  = ~idx_oor & loaded_q & val_ok;

	assign fill_go = loaded_q & ~(index_end > usable) & ({1'b0, index} < index_end);
	assign flush_go = loaded_q & dm_stat.any_dirty & dm_stat.nonempty;

	assign fill_final  = ({1'b0, x_q} + fcd_pkg::CNT_W'(1)) == end_q;
	assign clear_final = (x_q == {fcd_pkg::IDX_W{1'b1}});

	// entry ram write port: walk has priority, otherwise a set or load transfer
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = index;
		mem_wdata = value;
		case (state_q)
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = x_q;
				mem_wdata = fill_val_q;
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = x_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_we = accept && ((operation == fcd_pkg::OP_SET && set_ok) ||
					(operation == fcd_pkg::OP_LOAD &&
					 {1'b0, index} < fcd_pkg::CNT_W'(fcd_pkg::ENTRIES)));
			end
			default: begin
			end
		endcase
	end

	// dirty map commands
	always_comb begin
		dm_cmd.mark      = (state_q == S_FILL) ||
			(accept && operation == fcd_pkg::OP_SET && set_ok);
		dm_cmd.blk       = fcd_pkg::block_of((state_q == S_FILL) ? x_q : index,
			cfg.block_size_log2);
		dm_cmd.clear_all = accept && operation == fcd_pkg::OP_INVAL;
		dm_cmd.take      = (state_q == S_FLUSH);
		dm_cmd.set_any   = accept && operation == fcd_pkg::OP_SET && set_ok;
		dm_cmd.clr_any   = accept && (operation == fcd_pkg::OP_INVAL ||
			(operation == fcd_pkg::OP_FLUSH && flush_go));
	end

	// result generation and next state
	always_comb begin
		emit        = 1'b0;
		emit_status = fcd_pkg::STAT_OK;
		emit_last   = 1'b1;
		emit_ev     = '0;
		emit_bn     = '0;
		state_nxt   = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					case (operation)
						fcd_pkg::OP_GET: begin
							if (idx_oor) begin
								emit_status = fcd_pkg::STAT_RANGE;
							end else if (!loaded_q) begin
								emit_status = fcd_pkg::STAT_NOT_LOAD;
							end else begin
								emit      = 1'b0;
								state_nxt = S_GET;
							end
						end
						fcd_pkg::OP_SET: begin
							if (idx_oor) begin
								emit_status = fcd_pkg::STAT_RANGE;
							end else if (!loaded_q) begin
								emit_status = fcd_pkg::STAT_NOT_LOAD;
							end else if (!val_ok) begin
								emit_status = fcd_pkg::STAT_ILLEGAL;
							end
						end
						fcd_pkg::OP_FILL: begin
							if (!loaded_q) begin
								emit_status = fcd_pkg::STAT_NOT_LOAD;
							end else if (index_end > usable) begin
								emit_status = fcd_pkg::STAT_RANGE;
							end else if (fill_go) begin
								emit      = 1'b0;
								state_nxt = S_FILL;
							end
						end
						fcd_pkg::OP_LOAD: begin
							if ({1'b0, index} >= fcd_pkg::CNT_W'(fcd_pkg::ENTRIES)) begin
								emit_status = fcd_pkg::STAT_RANGE;
							end
						end
						fcd_pkg::OP_FLUSH: begin
							if (!loaded_q) begin
								emit_status = fcd_pkg::STAT_NOT_LOAD;
							end else if (!flush_go) begin
								emit_status = fcd_pkg::STAT_NOTHING;
							end else begin
								emit      = 1'b0;
								state_nxt = S_FLUSH;
							end
						end
						fcd_pkg::OP_INVAL: begin
							emit      = 1'b0;
							state_nxt = S_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			S_GET: begin
				emit      = 1'b1;
				emit_ev   = mem_rdata;
				state_nxt = S_IDLE;
			end
			S_FILL: begin
				if (fill_final) begin
					emit      = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_FLUSH: begin
				emit      = 1'b1;
				emit_last = dm_stat.rest_empty;
				emit_bn   = cfg.first_table_block + fcd_pkg::DATA_W'(dm_stat.low_blk);
				if (dm_stat.rest_empty) begin
					state_nxt = S_IDLE;
				end
			end
			S_CLEAR: begin
				if (clear_final) begin
					emit      = report_q;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// control state; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			x_q      <= '0;
			loaded_q <= 1'b0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= emit;
			if (state_q == S_IDLE && accept) begin
				if (operation == fcd_pkg::OP_FILL) begin
					x_q <= index;
				end else if (operation == fcd_pkg::OP_INVAL) begin
					x_q      <= '0;
					report_q <= 1'b1;
					loaded_q <= 1'b0;
				end else if (operation == fcd_pkg::OP_MARK) begin
					loaded_q <= 1'b1;
				end
			end else if (state_q == S_FILL || state_q == S_CLEAR) begin
				x_q <= x_q + fcd_pkg::IDX_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && operation == fcd_pkg::OP_FILL) begin
			end_q      <= index_end;
			fill_val_q <= value;
		end
		status_q <= emit_status;
		last_q   <= emit_last;
		ev_q     <= emit_ev;
		bn_q     <= emit_bn;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign last         = last_q;
	assign entry_value  = ev_q;
	assign block_number = bn_q;

	// flush only runs while a dirty block is pending
	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> dm_stat.nonempty)
		else $error("flush running with no dirty block");

	// a non-final result only comes from an ongoing flush
	a_partial_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !last_q) |-> (state_q == S_FLUSH))
		else $error("non-final result outside flush");

	// fill pointer stays inside its range
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> ({1'b0, x_q} < end_q))
		else $error("fill pointer past range end");

	// the table is never marked loaded while being cleared
	a_clear_unloaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !loaded_q)
		else $error("table loaded during clearing pass");

	// get result is produced in the cycle after the read state
	a_get_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GET) |=> (done_q && last_q && status_q == fcd_pkg::STAT_OK))
		else $error("get read without result");

endmodule

>>> sv/fcd_table.sv
// ----------------------------------------------------------------------------
// fcd_table
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fcd_table (
	input  logic                         clk,
	input  logic                         we,
	input  logic [fcd_pkg::IDX_W-1:0]    waddr,
	input  logic [fcd_pkg::DATA_W-1:0]   wdata,
	input  logic [fcd_pkg::IDX_W-1:0]    raddr,
	output logic [fcd_pkg::DATA_W-1:0]   rdata
);

	logic [fcd_pkg::DATA_W-1:0] mem [fcd_pkg::ENTRIES];
	logic [fcd_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/fcd_dirty_map.sv
// ----------------------------------------------------------------------------
// fcd_dirty_map
// per-block dirty bits, summary flag and lowest-dirty-block search for flush
// ----------------------------------------------------------------------------
module fcd_dirty_map (
	input  logic                clk,
	input  logic                arst_n,
	input  fcd_pkg::dm_cmd_t    cmd,
	output fcd_pkg::dm_stat_t   stat
);

	logic [fcd_pkg::MAX_BLOCKS-1:0] dirty_q;
	logic                           any_q;
	logic [fcd_pkg::MAX_BLOCKS-1:0] low_bit;
	logic [fcd_pkg::MAX_BLOCKS-1:0] rest;
	logic [fcd_pkg::BLK_W-1:0]      low_idx;

	// isolate lowest set bit
	assign low_bit = dirty_q & (~dirty_q + fcd_pkg::MAX_BLOCKS'(1));
	assign rest    = dirty_q & ~low_bit;

	// one-hot to binary
	always_comb begin
		low_idx = '0;
		for (int i = 0; i < fcd_pkg::MAX_BLOCKS; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | fcd_pkg::BLK_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
			any_q   <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				dirty_q <= '0;
			end else if (cmd.take) begin
				dirty_q <= rest;
			end else if (cmd.mark) begin
				dirty_q[cmd.blk] <= 1'b1;
			end
			if (cmd.clr_any) begin
				any_q <= 1'b0;
			end else if (cmd.set_any) begin
				any_q <= 1'b1;
			end
		end
	end

	assign stat.nonempty   = |dirty_q;
	assign stat.any_dirty  = any_q;
	assign stat.low_blk    = low_idx;
	assign stat.rest_empty = ~|rest;

endmodule

>>> sv/fcd_regs.sv
// ----------------------------------------------------------------------------
// fcd_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module fcd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcd_pkg::ADDR_W-1:0]    paddr,
	input  logic [fcd_pkg::DATA_W-1:0]    pwdata,
	output logic [fcd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output fcd_pkg::cfg_t                 cfg
);

	fcd_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_count       <= fcd_pkg::CNT_W'(4096);
			cfg_q.block_size_log2   <= fcd_pkg::BSL_W'(9);
			cfg_q.first_table_block <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				fcd_pkg::REG_ENTRY_COUNT: begin
					cfg_q.entry_count <= pwdata[fcd_pkg::CNT_W-1:0];
				end
				fcd_pkg::REG_BLOCK_LOG2: begin
					cfg_q.block_size_log2 <= pwdata[fcd_pkg::BSL_W-1:0];
				end
				fcd_pkg::REG_FIRST_BLOCK: begin
					cfg_q.first_table_block <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			fcd_pkg::REG_ENTRY_COUNT: prdata = fcd_pkg::DATA_W'(cfg_q.entry_count);
			fcd_pkg::REG_BLOCK_LOG2:  prdata = fcd_pkg::DATA_W'(cfg_q.block_size_log2);
			fcd_pkg::REG_FIRST_BLOCK: prdata = cfg_q.first_table_block;
			default:                  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> tb/fat_entry_cache_dirty_map_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_entry_cache_dirty_map_top_tb
// self-checking bench for the entry cache: a short directed table, then random
// command streams over several register settings; every result is compared
// with a prediction from a mirror of the entry table, the dirty-block map and
// the two flags, or with the typed-in result of a directed row
module fat_entry_cache_dirty_map_top_tb;

	// code 7 is not assigned to any operation
	localparam logic [fcd_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

	// a fill or clear walk over the whole table runs with nothing moving
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int N_PHASES        = 6;
	localparam int DRAIN_CYCLES    = 8;

	// one result transfer as seen on the result ports
	typedef struct packed {
		logic [fcd_pkg::DATA_W-1:0] entry_value;
		logic [fcd_pkg::DATA_W-1:0] block_number;
		logic [fcd_pkg::ST_W-1:0]   status;
		logic                       last;
	} reply_t;

	// directed row: command fields, plus a typed-in result where it is obvious
	typedef struct packed {
		logic [fcd_pkg::OP_W-1:0]   op;
		logic [fcd_pkg::IDX_W-1:0]  idx;
		logic [fcd_pkg::CNT_W-1:0]  idx_end;
		logic [fcd_pkg::DATA_W-1:0] val;
		logic                       typed;
		logic [fcd_pkg::ST_W-1:0]   st;
		logic [fcd_pkg::DATA_W-1:0] ev;
	} dir_row_t;

	localparam int DIR_N = 26;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// nothing works on an unloaded table except load, mark and invalidate
		'{fcd_pkg::OP_GET, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_NOT_LOAD, 32'h0},
		'{fcd_pkg::OP_SET, 12'd5, 13'd0, 32'h1, 1'b1, fcd_pkg::STAT_NOT_LOAD, 32'h0},
		'{fcd_pkg::OP_FILL, 12'd0, 13'd4, 32'h9, 1'b1, fcd_pkg::STAT_NOT_LOAD, 32'h0},
		'{fcd_pkg::OP_FLUSH, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_NOT_LOAD, 32'h0},
		'{fcd_pkg::OP_LOAD, 12'd4095, 13'd0, 32'hFFFF_FFFF, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_LOAD, 12'd0, 13'd0, 32'h1234_5678, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_MARK, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_GET, 12'd4095, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_OK, 32'hFFFF_FFFF},
		'{fcd_pkg::OP_GET, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_OK, 32'h1234_5678},
		// value checks: at entry_count, special range edges, just below it
		'{fcd_pkg::OP_SET, 12'd10, 13'd0, 32'h0000_1000, 1'b1, fcd_pkg::STAT_ILLEGAL, 32'h0},
		'{fcd_pkg::OP_SET, 12'd10, 13'd0, 32'hFFFF_FFF0, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_SET, 12'd11, 13'd0, 32'hFFFF_FFFF, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_SET, 12'd4095, 13'd0, 32'h0000_0FFF, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_SET, 12'd12, 13'd0, 32'hFFFF_FFEF, 1'b1, fcd_pkg::STAT_ILLEGAL, 32'h0},
		'{fcd_pkg::OP_GET, 12'd10, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_OK, 32'hFFFF_FFF0},
		// first and last block dirty, then nothing left to write
		'{fcd_pkg::OP_FLUSH, 12'd0, 13'd0, 32'h0, 1'b0, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_FLUSH, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_NOTHING, 32'h0},
		// empty fill, fill past the end, fill up to the very end
		'{fcd_pkg::OP_FILL, 12'd5, 13'd5, 32'hAAAA_AAAA, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_FILL, 12'd0, 13'd4097, 32'h0, 1'b1, fcd_pkg::STAT_RANGE, 32'h0},
		'{fcd_pkg::OP_FILL, 12'd4090, 13'd4096, 32'h7, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		// fill marks blocks but leaves the summary flag clear
		'{fcd_pkg::OP_FLUSH, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_NOTHING, 32'h0},
		'{fcd_pkg::OP_SET, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_FLUSH, 12'd0, 13'd0, 32'h0, 1'b0, fcd_pkg::STAT_OK, 32'h0},
		'{OP_UNUSED, 12'd4095, 13'd8191, 32'hFFFF_FFFF, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_INVAL, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_OK, 32'h0},
		'{fcd_pkg::OP_GET, 12'd0, 13'd0, 32'h0, 1'b1, fcd_pkg::STAT_NOT_LOAD, 32'h0}
	};

	// dut ports
	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [fcd_pkg::OP_W-1:0]   operation;
	logic [fcd_pkg::IDX_W-1:0]  index;
	logic [fcd_pkg::CNT_W-1:0]  index_end;
	logic [fcd_pkg::DATA_W-1:0] value;
	logic                       done;
	logic [fcd_pkg::DATA_W-1:0] entry_value;
	logic [fcd_pkg::DATA_W-1:0] block_number;
	logic [fcd_pkg::ST_W-1:0]   status;
	logic                       last;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [fcd_pkg::ADDR_W-1:0] paddr;
	logic [fcd_pkg::DATA_W-1:0] pwdata;
	logic [fcd_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	// typed-in expectation travelling with the command being driven
	logic                       row_typed;
	logic [fcd_pkg::ST_W-1:0]   row_status;
	logic [fcd_pkg::DATA_W-1:0] row_entry;

	// mirror of the cache contents and of the registers
	logic [fcd_pkg::DATA_W-1:0]     entry_mirror [fcd_pkg::ENTRIES];
	logic [fcd_pkg::MAX_BLOCKS-1:0] dirty_mirror;
	logic                           any_dirty_mirror;
	logic                           loaded_mirror;
	logic [fcd_pkg::CNT_W-1:0]      cfg_count;
	logic [fcd_pkg::BSL_W-1:0]      cfg_bsl;
	logic [fcd_pkg::DATA_W-1:0]     cfg_first;

	// results still owed by the block, oldest first
	reply_t reply_q [$];

	int        err_count;
	int        cmd_count;
	int        result_count;
	int        writeback_count;
	logic [7:0] op_seen;
	int        sender_idle_pct;
	int        stall_cycles;

	fat_entry_cache_dirty_map_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.index        (index),
		.index_end    (index_end),
		.value        (value),
		.done         (done),
		.entry_value  (entry_value),
		.block_number (block_number),
		.status       (status),
		.last         (last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void log_error(input string msg);
		err_count++;
		$display("%0t ns: %s", $time, msg);
	endfunction

	function automatic void flag_mismatch(input string what,
		input logic [fcd_pkg::DATA_W-1:0] want_v, input logic [fcd_pkg::DATA_W-1:0] got_v);
		log_error($sformatf("%s mismatch, expected %h, actual %h", what, want_v, got_v));
	endfunction

	// entries reachable by get, set and fill
	function automatic logic [fcd_pkg::CNT_W-1:0] usable_entries();
		return (cfg_count < fcd_pkg::CNT_W'(fcd_pkg::ENTRIES)) ?
			cfg_count : fcd_pkg::CNT_W'(fcd_pkg::ENTRIES);
	endfunction

	// disk block holding an entry; block size never below 256 bytes
	function automatic int blk_index(input logic [fcd_pkg::IDX_W-1:0] i);
		logic [fcd_pkg::BSL_W-1:0] sh;
		logic [fcd_pkg::IDX_W+1:0] byte_blk;
		sh       = (cfg_bsl < fcd_pkg::MIN_BSL) ? fcd_pkg::MIN_BSL : cfg_bsl;
		byte_blk = {i, 2'b00} >> sh;
		return (byte_blk > (fcd_pkg::IDX_W+2)'(fcd_pkg::MAX_BLOCKS - 1)) ?
			fcd_pkg::MAX_BLOCKS - 1 : int'(byte_blk);
	endfunction

	function automatic void push_reply(input logic [fcd_pkg::DATA_W-1:0] ev,
		input logic [fcd_pkg::DATA_W-1:0] bn, input logic [fcd_pkg::ST_W-1:0] st,
		input logic lst);
		reply_q.push_back('{ev, bn, st, lst});
	endfunction

	// applies one command to the mirror and queues the results it owes
	function automatic void predict_cache_op(input logic [fcd_pkg::OP_W-1:0] op,
		input logic [fcd_pkg::IDX_W-1:0] i, input logic [fcd_pkg::CNT_W-1:0] e,
		input logic [fcd_pkg::DATA_W-1:0] v);
		logic [fcd_pkg::CNT_W-1:0] cnt;
		int x;
		int b_lo;
		int b_hi;
		int total;
		int n;
		cnt = usable_entries();
		case (op)
			fcd_pkg::OP_GET: begin
				if ({1'b0, i} >= cnt) push_reply('0, '0, fcd_pkg::STAT_RANGE, 1'b1);
				else if (!loaded_mirror) push_reply('0, '0, fcd_pkg::STAT_NOT_LOAD, 1'b1);
				else push_reply(entry_mirror[i], '0, fcd_pkg::STAT_OK, 1'b1);
			end
			fcd_pkg::OP_SET: begin
				if ({1'b0, i} >= cnt) push_reply('0, '0, fcd_pkg::STAT_RANGE, 1'b1);
				else if (!loaded_mirror) push_reply('0, '0, fcd_pkg::STAT_NOT_LOAD, 1'b1);
				else if ((v & fcd_pkg::SPECIAL_MASK) != fcd_pkg::SPECIAL_MASK &&
					v >= fcd_pkg::DATA_W'(cfg_count)) begin
					push_reply('0, '0, fcd_pkg::STAT_ILLEGAL, 1'b1);
				end else begin
					entry_mirror[i]          = v;
					dirty_mirror[blk_index(i)] = 1'b1;
					any_dirty_mirror         = 1'b1;
					push_reply('0, '0, fcd_pkg::STAT_OK, 1'b1);
				end
			end
			fcd_pkg::OP_FILL: begin
				if (!loaded_mirror) push_reply('0, '0, fcd_pkg::STAT_NOT_LOAD, 1'b1);
				else if (e > cnt) push_reply('0, '0, fcd_pkg::STAT_RANGE, 1'b1);
				else begin
					if ({1'b0, i} < e) begin
						for (x = i; x < e; x++) entry_mirror[x] = v;
						b_lo = blk_index(i);
						b_hi = blk_index(fcd_pkg::IDX_W'(e - 1'b1));
						for (x = b_lo; x <= b_hi; x++) dirty_mirror[x] = 1'b1;
					end
					push_reply('0, '0, fcd_pkg::STAT_OK, 1'b1);
				end
			end
			fcd_pkg::OP_LOAD: begin
				entry_mirror[i] = v;
				push_reply('0, '0, fcd_pkg::STAT_OK, 1'b1);
			end
			fcd_pkg::OP_MARK: begin
				loaded_mirror = 1'b1;
				push_reply('0, '0, fcd_pkg::STAT_OK, 1'b1);
			end
			fcd_pkg::OP_FLUSH: begin
				if (!loaded_mirror) push_reply('0, '0, fcd_pkg::STAT_NOT_LOAD, 1'b1);
				else if (!any_dirty_mirror || dirty_mirror == '0) begin
					push_reply('0, '0, fcd_pkg::STAT_NOTHING, 1'b1);
				end else begin
					any_dirty_mirror = 1'b0;
					total = $countones(dirty_mirror);
					n     = 0;
					for (x = 0; x < fcd_pkg::MAX_BLOCKS; x++) begin
						if (dirty_mirror[x]) begin
							n++;
							push_reply('0, cfg_first + fcd_pkg::DATA_W'(x), fcd_pkg::STAT_OK,
								n == total);
						end
					end
					writeback_count += total;
					dirty_mirror = '0;
				end
			end
			fcd_pkg::OP_INVAL: begin
				for (x = 0; x < fcd_pkg::ENTRIES; x++) entry_mirror[x] = '0;
				dirty_mirror     = '0;
				any_dirty_mirror = 1'b0;
				loaded_mirror    = 1'b0;
				push_reply('0, '0, fcd_pkg::STAT_OK, 1'b1);
			end
			default: begin
				push_reply('0, '0, fcd_pkg::STAT_OK, 1'b1);
			end
		endcase
	endfunction

	// command and result transfers, both taken at the rising edge
	always @(posedge clk) begin : result_check
		reply_t want;
		int depth;
		if (arst_n && start && !busy) begin
			depth = reply_q.size();
			predict_cache_op(operation, index, index_end, value);
			cmd_count++;
			op_seen[operation] = 1'b1;
			// a typed-in row replaces what the mirror worked out
			if (row_typed) begin
				while (reply_q.size() > depth) void'(reply_q.pop_back());
				reply_q.push_back('{row_entry, fcd_pkg::DATA_W'(0), row_status, 1'b1});
			end
		end
		if (arst_n && done) begin
			result_count++;
			if (reply_q.size() == 0) begin
				log_error($sformatf("result transfer with nothing outstanding, status %0d, last %0b",
					status, last));
			end else begin
				want = reply_q.pop_front();
				if (entry_value !== want.entry_value) begin
					flag_mismatch("entry_value", want.entry_value, entry_value);
				end
				if (block_number !== want.block_number) begin
					flag_mismatch("block_number", want.block_number, block_number);
				end
				if (status !== want.status) begin
					flag_mismatch("status", fcd_pkg::DATA_W'(want.status),
						fcd_pkg::DATA_W'(status));
				end
				if (last !== want.last) begin
					flag_mismatch("last", fcd_pkg::DATA_W'(want.last), fcd_pkg::DATA_W'(last));
				end
			end
		end
	end

	// ends the run when nothing has moved for too long
	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (psel && penable && pready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// one command transfer; the sender may idle first
	task automatic send_cmd(input logic [fcd_pkg::OP_W-1:0] op,
		input logic [fcd_pkg::IDX_W-1:0] i, input logic [fcd_pkg::CNT_W-1:0] e,
		input logic [fcd_pkg::DATA_W-1:0] v, input logic typed,
		input logic [fcd_pkg::ST_W-1:0] st, input logic [fcd_pkg::DATA_W-1:0] ev);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start      = 1'b1;
		operation  = op;
		index      = i;
		index_end  = e;
		value      = v;
		row_typed  = typed;
		row_status = st;
		row_entry  = ev;
		do @(posedge clk); while (busy);
	endtask

	// write a register, then read it back through the same port
	task automatic reg_write_check(input logic [1:0] r,
		input logic [fcd_pkg::DATA_W-1:0] d, input logic [fcd_pkg::DATA_W-1:0] mask);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {r, 2'b00};
		pwdata  = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (d & mask)) begin
			flag_mismatch($sformatf("register %0d readback", r), d & mask, prdata & mask);
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic apply_setting(input logic [fcd_pkg::CNT_W-1:0] cnt,
		input logic [fcd_pkg::BSL_W-1:0] bsl, input logic [fcd_pkg::DATA_W-1:0] first);
		reg_write_check(fcd_pkg::REG_ENTRY_COUNT, fcd_pkg::DATA_W'(cnt),
			fcd_pkg::DATA_W'({fcd_pkg::CNT_W{1'b1}}));
		reg_write_check(fcd_pkg::REG_BLOCK_LOG2, fcd_pkg::DATA_W'(bsl),
			fcd_pkg::DATA_W'({fcd_pkg::BSL_W{1'b1}}));
		reg_write_check(fcd_pkg::REG_FIRST_BLOCK, first, '1);
		cfg_count = cnt;
		cfg_bsl   = bsl;
		cfg_first = first;
	endtask

	// wait for every owed result and for any clearing walk to finish
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (reply_q.size() != 0 || busy) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly in range, often at the edges, sometimes anywhere
	function automatic logic [fcd_pkg::IDX_W-1:0] pick_index(input int cnt);
		int r;
		r = $urandom_range(99);
		if (r < 70) return fcd_pkg::IDX_W'($urandom_range(cnt - 1));
		if (r < 78) return fcd_pkg::IDX_W'(cnt - 1);
		if (r < 84) return '0;
		if (r < 90) return '1;
		return fcd_pkg::IDX_W'($urandom());
	endfunction

	// well-formed traffic on a loaded table, with some noise mixed in
	task automatic random_cmd();
		logic [fcd_pkg::OP_W-1:0]   op;
		logic [fcd_pkg::IDX_W-1:0]  i;
		logic [fcd_pkg::CNT_W-1:0]  e;
		logic [fcd_pkg::DATA_W-1:0] v;
		int cnt;
		int r;
		cnt = usable_entries();
		i   = pick_index(cnt);
		e   = fcd_pkg::CNT_W'($urandom_range(8191));
		v   = $urandom();
		if (!loaded_mirror && $urandom_range(99) < 60) begin
			op = fcd_pkg::OP_MARK;
		end else begin
			r = $urandom_range(99);
			if (r < 22) begin
				op = fcd_pkg::OP_GET;
			end else if (r < 46) begin
				op = fcd_pkg::OP_SET;
				r  = $urandom_range(99);
				// special codes, ordinary cluster numbers, or anything
				if (r < 40) v = fcd_pkg::SPECIAL_MASK | fcd_pkg::DATA_W'($urandom_range(15));
				else if (r < 80) v = fcd_pkg::DATA_W'($urandom_range(cfg_count - 1));
			end else if (r < 58) begin
				op = fcd_pkg::OP_FILL;
				i  = fcd_pkg::IDX_W'($urandom_range(cnt - 1));
				r  = $urandom_range(99);
				// short runs mostly; a rare whole-table fill is slow
				if (r < 80) e = fcd_pkg::CNT_W'(i + $urandom_range(16));
				else if (r < 84) begin
					i = '0;
					e = fcd_pkg::CNT_W'(cnt);
				end else if (r < 92) e = fcd_pkg::CNT_W'($urandom_range(i));
				if ($urandom_range(1)) begin
					v = fcd_pkg::SPECIAL_MASK | fcd_pkg::DATA_W'($urandom_range(15));
				end
			end else if (r < 68) begin
				op = fcd_pkg::OP_LOAD;
			end else if (r < 80) begin
				op = fcd_pkg::OP_FLUSH;
			end else if (r < 85) begin
				op = fcd_pkg::OP_MARK;
			end else if (r < 87) begin
				op = fcd_pkg::OP_INVAL;
			end else if (r < 90) begin
				op = OP_UNUSED;
			end else begin
				op = fcd_pkg::OP_W'($urandom_range(7));
				i  = fcd_pkg::IDX_W'($urandom());
			end
		end
		send_cmd(op, i, e, v, 1'b0, fcd_pkg::STAT_OK, '0);
	endtask

	initial begin : stimulus
		logic [fcd_pkg::CNT_W-1:0]  ph_count [N_PHASES];
		logic [fcd_pkg::BSL_W-1:0]  ph_bsl   [N_PHASES];
		logic [fcd_pkg::DATA_W-1:0] ph_first [N_PHASES];
		int k;
		int p;

		// every input known from time zero while reset is held
		arst_n     = 1'b0;
		start      = 1'b0;
		operation  = fcd_pkg::OP_GET;
		index      = '0;
		index_end  = '0;
		value      = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		row_typed  = 1'b0;
		row_status = fcd_pkg::STAT_OK;
		row_entry  = '0;
		err_count       = 0;
		cmd_count       = 0;
		result_count    = 0;
		writeback_count = 0;
		op_seen         = '0;
		sender_idle_pct = 11;
		for (k = 0; k < fcd_pkg::ENTRIES; k++) entry_mirror[k] = '0;
		dirty_mirror     = '0;
		any_dirty_mirror = 1'b0;
		loaded_mirror    = 1'b0;
		cfg_count        = fcd_pkg::CNT_W'(4096);
		cfg_bsl          = 4'd9;
		cfg_first        = '0;

		// register settings: extremes, a middle one and random ones
		ph_count[0] = fcd_pkg::CNT_W'(4096);      ph_bsl[0] = 4'd8;
		ph_first[0] = 32'hFFFF_FFF0;              // 64 blocks, block number wraps
		ph_count[1] = fcd_pkg::CNT_W'(1);         ph_bsl[1] = 4'd14;
		ph_first[1] = 32'h0000_0000;
		ph_count[2] = fcd_pkg::CNT_W'($urandom_range(4096, 1));
		ph_bsl[2]   = fcd_pkg::BSL_W'($urandom_range(14, 8));
		ph_first[2] = $urandom();
		ph_count[3] = fcd_pkg::CNT_W'(4096);      ph_bsl[3] = 4'd14;
		ph_first[3] = 32'hFFFF_FFFF;
		ph_count[4] = fcd_pkg::CNT_W'(2048);      ph_bsl[4] = 4'd10;
		ph_first[4] = $urandom();
		ph_count[5] = fcd_pkg::CNT_W'($urandom_range(4096, 1));
		ph_bsl[5]   = 4'd8;
		ph_first[5] = $urandom();

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed table at reset register values; the first transfer
		// simply waits out the clearing walk after reset
		for (k = 0; k < DIR_N; k++) begin
			send_cmd(DIR_ROWS[k].op, DIR_ROWS[k].idx, DIR_ROWS[k].idx_end, DIR_ROWS[k].val,
				DIR_ROWS[k].typed, DIR_ROWS[k].st, DIR_ROWS[k].ev);
		end

		// random phases; sender idles 11, then 53, then 0 percent
		for (p = 0; p < N_PHASES; p++) begin
			settle();
			sender_idle_pct = (p < 2) ? 11 : (p < 4) ? 53 : 0;
			apply_setting(ph_count[p], ph_bsl[p], ph_first[p]);
			for (k = 0; k < ITEMS_PER_PHASE; k++) random_cmd();
		end

		settle();
		$display("covered %0d commands using %0d of 8 operation codes, %0d result transfers",
			cmd_count, $countones(op_seen), result_count);
		$display("including %0d block write-backs, over %0d register settings",
			writeback_count, N_PHASES + 1);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
